FILE: rtl/peak_suppression_1d_core_defines.svh
// Assertion macros for the 1-D peak suppression core.
// Included by the top level; expects signals clk and rst in scope.
`ifndef PEAK_SUPPRESSION_1D_CORE_DEFINES_SVH
`define PEAK_SUPPRESSION_1D_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define PSN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the following cycle.
`define PSN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/psn_pkg.sv
// Shared types and constants of the 1-D peak suppression core.
// No dependencies; used by psn_cell and peak_suppression_1d_core.
package psn_pkg;

  // Width of the half-width register, fixed by the register map.
  localparam int HW_BITS = 4;
  // Half width after reset.
  localparam logic [HW_BITS-1:0] HW_RESET = 4'd1;
  // Width of cell position arithmetic (covers the deepest window).
  localparam int POS_W = 8;

  // Control broadcast from the top level to every window cell.
  typedef struct packed {
    logic               shift;  // a sample beat is accepted
    logic               clear;  // the accepted beat starts a new sequence
    logic [HW_BITS-1:0] n;      // effective half width
  } cell_ctrl_t;

endpackage

FILE: rtl/psn_cell.sv
// One window cell: holds one sample, passes it to the next cell on each
// accepted beat and checks it against the broadcast candidate. Uses psn_pkg.
module psn_cell #(
  parameter int IDX         = 0,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  psn_pkg::cell_ctrl_t    ctrl,
  input  logic [SAMPLE_BITS-1:0] din,
  input  logic [SAMPLE_BITS-1:0] cand,
  output logic [SAMPLE_BITS-1:0] val,
  output logic                   ok
);

  localparam logic [psn_pkg::POS_W-1:0] IDX_P = psn_pkg::POS_W'(IDX);

  logic [psn_pkg::POS_W-1:0] n_p;
  logic [psn_pkg::POS_W-1:0] twice_n;
  logic                      newer;
  logic                      older;

  // Shift the sample along; a new sequence empties all cells behind the head.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val <= (ctrl.clear && (IDX != 0)) ? '0 : din;
    end
  end

  // Newer neighbors must be strictly below the candidate, older ones not above.
  always_comb begin
    n_p     = psn_pkg::POS_W'(ctrl.n);
    twice_n = psn_pkg::POS_W'({ctrl.n, 1'b0});
    newer   = IDX_P < n_p;
    older   = (IDX_P > n_p) && (IDX_P <= twice_n);
    if (newer) begin
      ok = cand > val;
    end else if (older) begin
      ok = cand >= val;
    end else begin
      ok = 1'b1;
    end
  end

endmodule

FILE: rtl/peak_suppression_1d_core.sv
// Top level of the 1-D peak suppression core: window cell chain, position
// counter, evaluation stage and output register. Uses psn_pkg, psn_cell.
//
// Channel | dir | handshake          | content
// s_*     | in  | s_tvalid/s_tready  | tdata: sample; tuser: first
// m_*     | out | m_tvalid/m_tready  | tdata: peak_index, peak_value
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: half_width
//
// One sample beat per cycle while s_tready is high. A beat shifts the cell
// chain at once; the evaluation stage then compares the candidate cell with
// its neighbors in parallel across the chain and loads a peak into the output
// register once it is free, for a beat that completes its neighborhood.
// s_tready drops only while an evaluation waits on a stalled output register.
// rst clears control state; there is no clearing pass.
`include "peak_suppression_1d_core_defines.svh"

module peak_suppression_1d_core #(
  parameter int MAX_HALF_WIDTH = 15,
  parameter int SAMPLE_BITS    = 16,
  parameter int INDEX_BITS     = 20
) (
  input  logic clk,
  input  logic rst,
  // sample beats
  input  logic                                           s_tvalid,
  output logic                                           s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]               s_tdata,  // [SAMPLE_BITS-1:0] sample
  input  logic                                           s_tuser,  // [0] first
  // peak beats
  output logic                                           m_tvalid,
  input  logic                                           m_tready,
  // [INDEX_BITS-1:0] peak_index, then SAMPLE_BITS peak_value
  output logic [((INDEX_BITS+SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
  // configuration
  input  logic                                           cfg_valid,
  output logic                                           cfg_ready,
  input  logic [psn_pkg::HW_BITS-1:0]                    cfg_data
);

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int SEL_W = $clog2(DEPTH);
  localparam int OUT_W = ((INDEX_BITS + SAMPLE_BITS + 7) / 8) * 8;
  localparam int CMP_W = INDEX_BITS + 1;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

  logic [psn_pkg::HW_BITS-1:0] half_width;
  logic [psn_pkg::HW_BITS-1:0] half_width_next;
  logic [INDEX_BITS-1:0]       position;
  logic [INDEX_BITS-1:0]       cur;
  logic                        elig;
  logic                        accept;
  logic                        advance;

  logic                        pend;
  logic                        pend_elig;
  logic [INDEX_BITS-1:0]       pend_idx;

  logic [INDEX_BITS-1:0]       out_index;
  logic [SAMPLE_BITS-1:0]      out_value;

  psn_pkg::cell_ctrl_t         ctrl;
  logic [SAMPLE_BITS-1:0]      win [DEPTH];
  logic [DEPTH-1:0]            ok;
  logic [SAMPLE_BITS-1:0]      cand;
  logic                        peak;

  // Configuration: always ready; store the clamped half width.
  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data == '0) begin
      half_width_next = psn_pkg::HW_BITS'(1);
    end else if (int'(cfg_data) > MAX_HALF_WIDTH) begin
      half_width_next = psn_pkg::HW_BITS'(MAX_HALF_WIDTH);
    end else begin
      half_width_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= psn_pkg::HW_RESET;
    end else if (cfg_valid) begin
      half_width <= half_width_next;
    end
  end

  // Handshake: the output register frees the evaluation stage.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !pend || advance;
  assign accept   = s_tvalid && s_tready;

  // Position of the incoming sample and whether its window is complete.
  always_comb begin
    cur  = s_tuser ? '0 : position;
    elig = (cur != IDX_MAX) &&
           (CMP_W'(cur) >= CMP_W'({half_width, 1'b0}));
  end

  // Advance the saturating position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      position <= (cur != IDX_MAX) ? cur + INDEX_BITS'(1) : cur;
    end
  end

  // Cell chain, newest sample in cell 0.
  assign ctrl.shift = accept;
  assign ctrl.clear = s_tuser;
  assign ctrl.n     = half_width;
  assign cand       = win[SEL_W'(half_width)];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      psn_cell #(
        .IDX         (i),
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .din  (s_tdata[SAMPLE_BITS-1:0]),
        .cand (cand),
        .val  (win[i]),
        .ok   (ok[i])
      );
    end else begin : g_body
      psn_cell #(
        .IDX         (i),
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .din  (win[i-1]),
        .cand (cand),
        .val  (win[i]),
        .ok   (ok[i])
      );
    end
  end

  assign peak = pend_elig && (&ok);

  // Evaluation stage: hold the beat's bookkeeping until the chain is checked.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (advance) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_elig <= elig;
      pend_idx  <= cur - INDEX_BITS'(half_width);
    end
  end

  // Output register: load a peak when free, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= pend && peak;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pend && peak) begin
      out_index <= pend_idx;
      out_value <= cand;
    end
  end

  assign m_tdata = OUT_W'({out_value, out_index});

  // Checks
  `PSN_ASSERT_NEXT(a_no_result_without_eval, !pend && advance, !m_tvalid,
                   "result appeared without a pending evaluation")
  `PSN_ASSERT_NEXT(a_first_restarts_count, accept && s_tuser,
                   position == INDEX_BITS'(1), "first beat did not restart position")
  `PSN_ASSERT(a_half_width_range,
              (half_width != '0) && (int'(half_width) <= MAX_HALF_WIDTH),
              "half width outside its range")

endmodule
